>>> hw/rtl/hid_keyboard_report_to_key_events_top_macros.svh
// Assertion macros used by the keyboard report decoder checker.
// Depends on nothing; included by the checker file.
`ifndef HID_KEYBOARD_REPORT_TO_KEY_EVENTS_TOP_MACROS_SVH
`define HID_KEYBOARD_REPORT_TO_KEY_EVENTS_TOP_MACROS_SVH

// Antecedent holds -> consequent holds in the same cycle.
`define HKR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hkr checker: same-cycle property failed");

// Antecedent holds -> consequent holds in the next cycle.
`define HKR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hkr checker: next-cycle property failed");

`endif

>>> hw/rtl/hkr_pkg.sv
// Shared types, constants and keycode table of the keyboard report decoder.
// Depends on nothing.
package hkr_pkg;

  localparam int unsigned KEY_SLOTS = 6;
  localparam int unsigned MOD_BITS = 8;
  localparam int unsigned NUM_EVENTS = MOD_BITS + 2 * KEY_SLOTS;

  localparam logic [7:0] MOD_USAGE_BASE = 8'd224;
  localparam logic [7:0] LAST_ERROR_USAGE = 8'd3;

  localparam logic KEY_RELEASED = 1'b0;
  localparam logic KEY_PRESSED = 1'b1;

  // One candidate key event.
  typedef struct packed {
    logic [7:0] code;
    logic       value;
  } evt_t;

  // What one slot lane found: a release of the old usage and a press of the new.
  typedef struct packed {
    logic rel_vld;
    evt_t rel;
    logic prs_vld;
    evt_t prs;
  } lane_evt_t;

  localparam logic [7:0] KEYCODE_ROM [256] = '{
      8'd0,   8'd0,   8'd0,   8'd0,   8'd30,  8'd48,  8'd46,  8'd32,
      8'd18,  8'd33,  8'd34,  8'd35,  8'd23,  8'd36,  8'd37,  8'd38,
      8'd50,  8'd49,  8'd24,  8'd25,  8'd16,  8'd19,  8'd31,  8'd20,
      8'd22,  8'd47,  8'd17,  8'd45,  8'd21,  8'd44,  8'd2,   8'd3,
      8'd4,   8'd5,   8'd6,   8'd7,   8'd8,   8'd9,   8'd10,  8'd11,
      8'd28,  8'd1,   8'd14,  8'd15,  8'd57,  8'd12,  8'd13,  8'd26,
      8'd27,  8'd43,  8'd43,  8'd39,  8'd40,  8'd41,  8'd51,  8'd52,
      8'd53,  8'd58,  8'd59,  8'd60,  8'd61,  8'd62,  8'd63,  8'd64,
      8'd65,  8'd66,  8'd67,  8'd68,  8'd87,  8'd88,  8'd99,  8'd70,
      8'd119, 8'd110, 8'd102, 8'd104, 8'd111, 8'd107, 8'd109, 8'd106,
      8'd105, 8'd108, 8'd103, 8'd69,  8'd98,  8'd55,  8'd74,  8'd78,
      8'd96,  8'd79,  8'd80,  8'd81,  8'd75,  8'd76,  8'd77,  8'd71,
      8'd72,  8'd73,  8'd82,  8'd83,  8'd86,  8'd127, 8'd116, 8'd117,
      8'd183, 8'd184, 8'd185, 8'd186, 8'd187, 8'd188, 8'd189, 8'd190,
      8'd191, 8'd192, 8'd193, 8'd194, 8'd134, 8'd138, 8'd130, 8'd132,
      8'd128, 8'd129, 8'd131, 8'd137, 8'd133, 8'd135, 8'd136, 8'd113,
      8'd115, 8'd114, 8'd0,   8'd0,   8'd0,   8'd121, 8'd0,   8'd89,
      8'd93,  8'd124, 8'd92,  8'd94,  8'd95,  8'd0,   8'd0,   8'd0,
      8'd122, 8'd123, 8'd90,  8'd91,  8'd85,  8'd0,   8'd0,   8'd0,
      8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
      8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
      8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
      8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
      8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
      8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
      8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
      8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
      8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
      8'd29,  8'd42,  8'd56,  8'd125, 8'd97,  8'd54,  8'd100, 8'd126,
      8'd164, 8'd166, 8'd165, 8'd163, 8'd161, 8'd115, 8'd114, 8'd113,
      8'd150, 8'd158, 8'd159, 8'd128, 8'd136, 8'd177, 8'd178, 8'd176,
      8'd142, 8'd152, 8'd173, 8'd140, 8'd0,   8'd0,   8'd0,   8'd0
  };

endpackage

>>> hw/rtl/hkr_slot_lane.sv
// One key slot lane: finds the release of the old usage and the press of the new.
// Depends on hkr_pkg for the keycode table and lane result struct.
module hkr_slot_lane
  import hkr_pkg::*;
(
  input  logic [7:0] old_usage_i,
  input  logic [7:0] new_usage_i,
  input  logic [7:0] old_slots_i [KEY_SLOTS],
  input  logic [7:0] new_slots_i [KEY_SLOTS],
  output lane_evt_t  evt_o
);

  logic       old_still_held;
  logic       new_was_held;
  logic [7:0] old_code;
  logic [7:0] new_code;

  // Look for each usage in the other report.
  always_comb begin
    old_still_held = 1'b0;
    new_was_held   = 1'b0;
    for (int k = 0; k < KEY_SLOTS; k++) begin
      if (new_slots_i[k] == old_usage_i) old_still_held = 1'b1;
      if (old_slots_i[k] == new_usage_i) new_was_held = 1'b1;
    end
  end

  assign old_code = KEYCODE_ROM[old_usage_i];
  assign new_code = KEYCODE_ROM[new_usage_i];

  // Drop error usages, keys without a mapping and keys held in both reports.
  assign evt_o.rel_vld    = (old_usage_i > LAST_ERROR_USAGE) && !old_still_held &&
                            (old_code != 8'd0);
  assign evt_o.rel.code   = old_code;
  assign evt_o.rel.value  = KEY_RELEASED;
  assign evt_o.prs_vld    = (new_usage_i > LAST_ERROR_USAGE) && !new_was_held &&
                            (new_code != 8'd0);
  assign evt_o.prs.code   = new_code;
  assign evt_o.prs.value  = KEY_PRESSED;

endmodule

>>> hw/rtl/hkr_serializer.sv
// Merging stage: holds one report's candidate events and sends them out in order.
// Depends on hkr_pkg for the event struct and event count.
module hkr_serializer
  import hkr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  logic [NUM_EVENTS-1:0] cand_mask_i,
  input  evt_t                  cand_evt_i [NUM_EVENTS],
  output logic                  ready_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [7:0]            event_code_o,
  output logic                  key_value_o,
  output logic                  last_in_run_o
);

  logic [NUM_EVENTS-1:0] mask_q, mask_d;
  evt_t                  evt_q [NUM_EVENTS];
  logic [NUM_EVENTS-1:0] pick;
  logic [NUM_EVENTS-1:0] rest;
  evt_t                  sel_evt;
  logic                  can_issue;
  logic                  issue;
  logic                  out_valid_q;
  logic [7:0]            code_q;
  logic                  value_q;
  logic                  last_q;

  // Pick the lowest pending event.
  assign pick = mask_q & (~mask_q + NUM_EVENTS'(1));
  assign rest = mask_q & ~pick;

  always_comb begin
    sel_evt = '0;
    for (int j = 0; j < NUM_EVENTS; j++) begin
      if (pick[j]) sel_evt = sel_evt | evt_q[j];
    end
  end

  assign can_issue = !out_valid_q || !out_stall_i;
  assign issue     = (mask_q != '0) && can_issue;
  assign ready_o   = (mask_q == '0) || (issue && (rest == '0));

  always_comb begin
    if (load_i) begin
      mask_d = cand_mask_i;
    end else if (issue) begin
      mask_d = rest;
    end else begin
      mask_d = mask_q;
    end
  end

  // Hold the pending mask.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  // Capture the candidate events of an accepted report.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      evt_q <= cand_evt_i;
    end
  end

  // Output register: advance on issue, drop after the transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (issue) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      code_q  <= sel_evt.code;
      value_q <= sel_evt.value;
      last_q  <= (rest == '0);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_code_o  = code_q;
  assign key_value_o   = value_q;
  assign last_in_run_o = last_q;

endmodule

>>> hw/rtl/hid_keyboard_report_to_key_events_top.sv
// Channel | dir | handshake            | payload
// in      | in  | in_valid_i/in_stall_o | modifier_bits_i, key_slot_0_i .. key_slot_5_i
// out     | out | out_valid_o/out_stall_i | event_code_o, key_value_o, last_in_run_o
//
// A report is compared with the stored one combinationally by eight modifier
// lanes and six slot lanes; the serializer then sends one event per cycle while
// out_stall_i is low. A report yields 0 to 20 events; an empty report leaves
// the serializer ready. The next report is taken in the cycle the last
// event of the previous run moves to the output register.
// Reset clears the stored report and all pending events; out_stall_i only
// holds the output register and the serializer behind it.
module hid_keyboard_report_to_key_events_top
  import hkr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] modifier_bits_i,
  input  logic [7:0] key_slot_0_i,
  input  logic [7:0] key_slot_1_i,
  input  logic [7:0] key_slot_2_i,
  input  logic [7:0] key_slot_3_i,
  input  logic [7:0] key_slot_4_i,
  input  logic [7:0] key_slot_5_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] event_code_o,
  output logic       key_value_o,
  output logic       last_in_run_o
);

  logic [7:0]            mods_q;
  logic [7:0]            slots_q [KEY_SLOTS];
  logic [7:0]            new_slots [KEY_SLOTS];
  logic                  ready;
  logic                  accept;
  logic [NUM_EVENTS-1:0] cand_mask;
  evt_t                  cand_evt [NUM_EVENTS];
  lane_evt_t             lane_evt [KEY_SLOTS];

  assign new_slots[0] = key_slot_0_i;
  assign new_slots[1] = key_slot_1_i;
  assign new_slots[2] = key_slot_2_i;
  assign new_slots[3] = key_slot_3_i;
  assign new_slots[4] = key_slot_4_i;
  assign new_slots[5] = key_slot_5_i;

  assign in_stall_o = !ready;
  assign accept     = in_valid_i && ready;

  // Modifier lanes: one event per changed bit.
  for (genvar g = 0; g < MOD_BITS; g++) begin : g_mod
    localparam logic [7:0] ModUsage = 8'(MOD_USAGE_BASE + g);
    assign cand_mask[g]      = modifier_bits_i[g] ^ mods_q[g];
    assign cand_evt[g].code  = KEYCODE_ROM[ModUsage];
    assign cand_evt[g].value = modifier_bits_i[g];
  end

  // Slot lanes: release then press per slot.
  for (genvar s = 0; s < KEY_SLOTS; s++) begin : g_slot
    hkr_slot_lane u_lane (
      .old_usage_i (slots_q[s]),
      .new_usage_i (new_slots[s]),
      .old_slots_i (slots_q),
      .new_slots_i (new_slots),
      .evt_o       (lane_evt[s])
    );
    assign cand_mask[MOD_BITS + 2 * s]     = lane_evt[s].rel_vld;
    assign cand_evt[MOD_BITS + 2 * s]      = lane_evt[s].rel;
    assign cand_mask[MOD_BITS + 2 * s + 1] = lane_evt[s].prs_vld;
    assign cand_evt[MOD_BITS + 2 * s + 1]  = lane_evt[s].prs;
  end

  // Store the accepted report for the next comparison.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mods_q <= '0;
      for (int k = 0; k < KEY_SLOTS; k++) slots_q[k] <= '0;
    end else if (accept) begin
      mods_q  <= modifier_bits_i;
      slots_q <= new_slots;
    end
  end

  hkr_serializer u_serializer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (accept),
    .cand_mask_i   (cand_mask),
    .cand_evt_i    (cand_evt),
    .ready_o       (ready),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .event_code_o  (event_code_o),
    .key_value_o   (key_value_o),
    .last_in_run_o (last_in_run_o)
  );

endmodule

>>> hw/rtl/hkr_checker.sv
// Port-level checks of the keyboard report decoder, bound to its top level.
// Depends on the assertion macro header.
`include "hid_keyboard_report_to_key_events_top_macros.svh"

module hkr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] modifier_bits_i,
  input logic [7:0] key_slot_0_i,
  input logic [7:0] key_slot_1_i,
  input logic [7:0] key_slot_2_i,
  input logic [7:0] key_slot_3_i,
  input logic [7:0] key_slot_4_i,
  input logic [7:0] key_slot_5_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] event_code_o,
  input logic       key_value_o,
  input logic       last_in_run_o
);

  // A stalled event holds.
  `HKR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
                   out_valid_o && $stable(event_code_o) && $stable(key_value_o)
                   && $stable(last_in_run_o))

  // A run is sent without gaps once its first event is out.
  `HKR_ASSERT_NEXT(a_run_contiguous, clk_i, rst_ni,
                   out_valid_o && !out_stall_i && !last_in_run_o, out_valid_o)

  // No new report while a stalled run still has events queued.
  `HKR_ASSERT_SAME(a_stall_mid_run, clk_i, rst_ni,
                   out_valid_o && out_stall_i && !last_in_run_o, in_stall_o)

  // Unmapped usages never reach the output.
  `HKR_ASSERT_SAME(a_code_mapped, clk_i, rst_ni, out_valid_o, event_code_o != 8'd0)

endmodule

bind hid_keyboard_report_to_key_events_top hkr_checker u_hkr_checker (.*);

>>> verif/tb.sv
// Self-checking bench for the keyboard report decoder.
// Directed and random reports in, key events out.
// Depends on hkr_pkg for the slot count, usage limits and keycode table, and on the top level.
module tb;
  import hkr_pkg::*;

  typedef logic [KEY_SLOTS-1:0][7:0] slot_row_t;

  typedef struct {
    logic [7:0] code;
    logic       value;
    logic       last;
  } key_event_t;

  // Track the held keys and queue the key events each report should cause.
  class key_event_board;
    logic [7:0]   held_mods;
    slot_row_t    held_slots;
    key_event_t   pending_events[$];
    int unsigned  reports_seen;
    int unsigned  empty_runs;
    int unsigned  events_checked;
    int unsigned  fails;

    function new();
      held_mods      = '0;
      held_slots     = '0;
      reports_seen   = 0;
      empty_runs     = 0;
      events_checked = 0;
      fails          = 0;
    endfunction

    function bit row_has(logic [7:0] usage, slot_row_t row);
      for (int s = 0; s < KEY_SLOTS; s++) begin
        if (row[s] == usage) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_failure(string msg);
      if (fails < 10) $display("mismatch %0d: %s", fails + 1, msg);
      fails++;
    endfunction

    function int unsigned outstanding();
      return pending_events.size();
    endfunction

    // Diff the new report against the held one and queue the resulting run.
    function void note_report(logic [7:0] mods, slot_row_t slots);
      key_event_t run[$];
      key_event_t ev;
      logic [7:0] old_u;
      logic [7:0] new_u;
      for (int b = 0; b < 8; b++) begin
        if (mods[b] != held_mods[b]) begin
          ev.code  = KEYCODE_ROM[MOD_USAGE_BASE + b];
          ev.value = mods[b] ? KEY_PRESSED : KEY_RELEASED;
          ev.last  = 1'b0;
          run.push_back(ev);
        end
      end
      for (int s = 0; s < KEY_SLOTS; s++) begin
        old_u = held_slots[s];
        new_u = slots[s];
        if (old_u > LAST_ERROR_USAGE && !row_has(old_u, slots)
            && KEYCODE_ROM[old_u] != 8'd0) begin
          ev.code  = KEYCODE_ROM[old_u];
          ev.value = KEY_RELEASED;
          ev.last  = 1'b0;
          run.push_back(ev);
        end
        if (new_u > LAST_ERROR_USAGE && !row_has(new_u, held_slots)
            && KEYCODE_ROM[new_u] != 8'd0) begin
          ev.code  = KEYCODE_ROM[new_u];
          ev.value = KEY_PRESSED;
          ev.last  = 1'b0;
          run.push_back(ev);
        end
      end
      if (run.size() > 0) run[run.size() - 1].last = 1'b1;
      else empty_runs++;
      foreach (run[k]) pending_events.push_back(run[k]);
      held_mods  = mods;
      held_slots = slots;
      reports_seen++;
    endfunction

    // Compare one output transfer with the oldest queued event.
    function void check_event(logic [7:0] code, logic value, logic last);
      key_event_t want;
      events_checked++;
      if (pending_events.size() == 0) begin
        note_failure($sformatf("unexpected event code=%0d value=%0b last=%0b",
                               code, value, last));
        return;
      end
      want = pending_events.pop_front();
      if (code !== want.code || value !== want.value || last !== want.last) begin
        note_failure($sformatf(
          "expected code=%0d value=%0b last=%0b, got code=%0d value=%0b last=%0b",
          want.code, want.value, want.last, code, value, last));
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] modifier_bits_i;
  logic [7:0] key_slot_0_i;
  logic [7:0] key_slot_1_i;
  logic [7:0] key_slot_2_i;
  logic [7:0] key_slot_3_i;
  logic [7:0] key_slot_4_i;
  logic [7:0] key_slot_5_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] event_code_o;
  logic       key_value_o;
  logic       last_in_run_o;

  key_event_board board;
  int unsigned    send_idle_pct;
  int unsigned    recv_idle_pct;
  bit             hold_req;
  logic [7:0]     cur_mods;
  slot_row_t      cur_slots;

  hid_keyboard_report_to_key_events_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .modifier_bits_i(modifier_bits_i),
    .key_slot_0_i   (key_slot_0_i),
    .key_slot_1_i   (key_slot_1_i),
    .key_slot_2_i   (key_slot_2_i),
    .key_slot_3_i   (key_slot_3_i),
    .key_slot_4_i   (key_slot_4_i),
    .key_slot_5_i   (key_slot_5_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .event_code_o   (event_code_o),
    .key_value_o    (key_value_o),
    .last_in_run_o  (last_in_run_o)
  );

  // Free-running clock, period 8.
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Drive out_stall_i: a requested long hold first, random idling otherwise.
  initial begin
    int unsigned hold_left;
    hold_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Check every accepted output transfer.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_event(event_code_o, key_value_o, last_in_run_o);
    end
  end

  // Bound the run.
  initial begin
    #2000000;
    $display("timeout with %0d events still queued", board.outstanding());
    $display("== FAIL ==");
    $finish;
  end

  function automatic slot_row_t mk_row(logic [7:0] a0, logic [7:0] a1, logic [7:0] a2,
                                       logic [7:0] a3, logic [7:0] a4, logic [7:0] a5);
    slot_row_t row;
    row[0] = a0;
    row[1] = a1;
    row[2] = a2;
    row[3] = a3;
    row[4] = a4;
    row[5] = a5;
    return row;
  endfunction

  // Mostly ordinary keys, with error codes, modifier usages and anything else mixed in.
  function automatic logic [7:0] pick_usage();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 75) return 8'($urandom_range(4, 8'h65));
    if (r < 85) return 8'($urandom_range(0, 3));
    if (r < 92) return 8'($urandom_range(8'he0, 8'he7));
    return 8'($urandom_range(0, 255));
  endfunction

  // Offer one report after random idle cycles; hold it until the transfer.
  task automatic send_report(logic [7:0] mods, slot_row_t slots);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i      <= 1'b0;
      modifier_bits_i <= 8'($urandom_range(0, 255));
      @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    modifier_bits_i <= mods;
    key_slot_0_i    <= slots[0];
    key_slot_1_i    <= slots[1];
    key_slot_2_i    <= slots[2];
    key_slot_3_i    <= slots[3];
    key_slot_4_i    <= slots[4];
    key_slot_5_i    <= slots[5];
    do @(posedge clk_i); while (in_stall_o);
    board.note_report(mods, slots);
    cur_mods  = mods;
    cur_slots = slots;
  endtask

  // Build the next random report: mostly typing, some repeats, rollover and raw noise.
  task automatic send_random_report();
    logic [7:0]  mods;
    slot_row_t   slots;
    int unsigned kind;
    int unsigned s;
    mods  = cur_mods;
    slots = cur_slots;
    kind  = $urandom_range(99);
    if (kind < 60) begin
      if ($urandom_range(99) < 30) mods[$urandom_range(7)] = ~mods[$urandom_range(7)];
      if ($urandom_range(99) < 15) mods[$urandom_range(7)] = ~mods[$urandom_range(7)];
      repeat ($urandom_range(0, 2)) begin
        s = $urandom_range(KEY_SLOTS - 1);
        slots[s] = $urandom_range(1) ? pick_usage() : 8'd0;
      end
      if ($urandom_range(99) < 10) slots[$urandom_range(KEY_SLOTS - 1)] = slots[0];
    end else if (kind < 70) begin
      // repeat the held report
    end else if (kind < 80) begin
      for (int k = 0; k < KEY_SLOTS; k++) slots[k] = 8'd1;
    end else begin
      mods = 8'($urandom_range(0, 255));
      for (int k = 0; k < KEY_SLOTS; k++) slots[k] = 8'($urandom_range(0, 255));
    end
    send_report(mods, slots);
  endtask

  // Pause the sender until every queued event has come out, plus a margin.
  task automatic drain_events();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  initial begin
    board           = new();
    send_idle_pct   = 17;
    recv_idle_pct   = 66;
    hold_req        = 1'b0;
    cur_mods        = '0;
    cur_slots       = '0;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    modifier_bits_i = '0;
    key_slot_0_i    = '0;
    key_slot_1_i    = '0;
    key_slot_2_i    = '0;
    key_slot_3_i    = '0;
    key_slot_4_i    = '0;
    key_slot_5_i    = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: modifier extremes, full swap, reorder, rollover, duplicates, unmapped usages.
    send_report(8'h00, mk_row(0, 0, 0, 0, 0, 0));
    send_report(8'hff, mk_row(0, 0, 0, 0, 0, 0));
    send_report(8'h00, mk_row(0, 0, 0, 0, 0, 0));
    send_report(8'h0f, mk_row(4, 5, 6, 7, 8, 9));
    send_report(8'hf0, mk_row(10, 11, 12, 13, 14, 15));
    send_report(8'hf0, mk_row(15, 14, 13, 12, 11, 10));
    send_report(8'hf0, mk_row(1, 1, 1, 1, 1, 1));
    send_report(8'hf0, mk_row(4, 4, 0, 0, 0, 0));
    send_report(8'hf0, mk_row(0, 0, 0, 0, 0, 0));
    send_report(8'hf0, mk_row(8'h82, 8'h83, 8'h84, 8'ha0, 8'hdf, 8'hfc));
    send_report(8'hf0, mk_row(8'h85, 8'h87, 8'he0, 8'he7, 8'h65, 8'hfb));
    send_report(8'hff, mk_row(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
    send_report(8'h00, mk_row(0, 2, 3, 4, 4, 8'h39));
    send_report(8'h55, mk_row(8'h39, 0, 0, 0, 0, 0));
    send_report(8'haa, mk_row(8'h04, 8'h1e, 8'h28, 8'h2c, 8'h50, 8'h64));
    send_report(8'haa, mk_row(8'h04, 8'h1e, 8'h28, 8'h2c, 8'h50, 8'h64));
    send_report(8'h00, mk_row(0, 0, 0, 0, 0, 0));
    drain_events();

    // Random, slow receiver.
    repeat (110) send_random_report();
    drain_events();

    // Random, slow sender.
    send_idle_pct = 66;
    recv_idle_pct = 17;
    repeat (55) send_random_report();
    drain_events();
    repeat (55) send_random_report();
    drain_events();

    // No idling; hold the receiver off long enough to back up the input.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req      = 1'b1;
    repeat (12) send_random_report();
    repeat (118) send_random_report();
    drain_events();

    $display("covered %0d reports (%0d with no events), %0d key events checked",
             board.reports_seen, board.empty_runs, board.events_checked);
    $display("under both idling mixes, a long receiver hold and drains; %0d mismatches",
             board.fails);
    if (board.fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/hkr_pkg.sv
hw/rtl/hkr_slot_lane.sv
hw/rtl/hkr_serializer.sv
hw/rtl/hid_keyboard_report_to_key_events_top.sv
hw/rtl/hkr_checker.sv
verif/tb.sv
